FILE: sv/amwmv_pkg.sv
// Package for the argmax / window majority vote block.
// Holds widths, the window entry type and the sequencer state type.
// No dependencies.
package amwmv_pkg;

	localparam int MAX_CLASSES  = 64;
	localparam int WINDOW_DEPTH = 16;

	localparam int SCORE_W   = 16;
	localparam int LABEL_W   = 6;
	localparam int CLASS_W   = $clog2(MAX_CLASSES);
	localparam int WLEN_W    = 5;
	localparam int WIDX_W    = $clog2(WINDOW_DEPTH);
	localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W     = SCORE_W + CNT_W;
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam int S_DATA_W  = SCORE_W;
	localparam int M_DATA_W  = ((LABEL_W + SCORE_W + 7) / 8) * 8;

	typedef struct packed {
		logic [CLASS_W-1:0] label;
		logic [SCORE_W-1:0] score;
	} vote_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

FILE: sv/argmax_with_window_majority_vote.sv
// Argmax over a stream of class scores followed by a majority vote over
// a window of recent decisions. Depends on amwmv_pkg.
//
// Usage:
//  s_* carries one class score per item (s_tdata), s_tlast on the final
//  score of a vector. Non-final items are taken at one per cycle while idle and only
//  update the running argmax; they produce nothing.
//  m_* carries one result per vector: m_tdata = {pad, score, label}.
//  cfg_we/cfg_wdata write window_length; 0 gives the raw argmax, values
//  above the window depth act as the depth.
//  With window_length 0 the final item's argmax goes straight to the
//  result stage. Otherwise the vote runs as a sequencer around one shared
//  adder/subtractor: L scan steps counting labels (L = effective window
//  length), L steps accumulating the winner's scores, then SUM_W restoring
//  divide steps (SUM_W = 21 here).
//  s_tready is low from the final item until its result moves into the
//  output register. The output register holds a result while m_tready is
//  low, and new non-final items are still accepted meanwhile; a finished
//  vote waits in its own stage until the output register frees up.
//  Reset clears the argmax, the window (label 0, score 0), window_length
//  and the output valid.
module argmax_with_window_majority_vote (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [amwmv_pkg::S_DATA_W-1:0]    s_tdata,   // [15:0] class_score
	input  logic                              s_tlast,   // last_class
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [amwmv_pkg::M_DATA_W-1:0]    m_tdata,   // [5:0] label, [21:6] score
	input  logic                              cfg_we,
	input  logic [amwmv_pkg::WLEN_W-1:0]      cfg_wdata  // window_length
);
	import amwmv_pkg::*;

	state_t state_q, state_d;

	logic [WLEN_W-1:0]  wl_q;
	logic [SCORE_W-1:0] best_score_q;
	logic [CLASS_W-1:0] best_label_q;
	logic [CLASS_W-1:0] cls_cnt_q;
	vote_t              win_q [WINDOW_DEPTH];

	logic [WLEN_W-1:0]  len_q;
	logic [WIDX_W-1:0]  idx_q;
	logic [STEP_W-1:0]  step_q;
	logic [CLASS_W-1:0] top_label_q;
	logic [CNT_W-1:0]   top_cnt_q;
	logic [SUM_W-1:0]   acc_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CLASS_W-1:0] res_label_q;
	logic [SCORE_W-1:0] res_score_q;

	logic               m_valid_q;
	logic [LABEL_W-1:0] m_label_q;
	logic [SCORE_W-1:0] m_score_q;

	// Running argmax with the current item folded in.
	logic               take;
	vote_t              nb;
	logic [WLEN_W-1:0]  len_c;
	logic               s_fire;
	logic               out_free;

	// Control from the sequencer.
	logic               ld_direct;
	logic               ld_vote;
	logic               idx_last;
	logic               to_out;

	// Scan and shared unit.
	vote_t              cur;
	logic [WINDOW_DEPTH-1:0] match;
	logic [CNT_W-1:0]   scan_cnt;
	logic [SUM_W-1:0]   alu_a, alu_b;
	logic               alu_sub;
	logic [SUM_W:0]     alu_y;
	logic [CNT_W:0]     rem_sh;
	logic               q_bit;

	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign take     = (cls_cnt_q == '0) || (s_tdata > best_score_q);
	assign nb.score = take ? s_tdata : best_score_q;
	assign nb.label = take ? cls_cnt_q : best_label_q;
	assign len_c    = (wl_q > WLEN_W'(WINDOW_DEPTH)) ? WLEN_W'(WINDOW_DEPTH) : wl_q;
	assign idx_last = (idx_q == '0);

	// Count of the current entry's label among entries scanned so far
	// (scan runs from the oldest entry at len-1 down to the newest at 0).
	assign cur = win_q[idx_q];
	always_comb begin
		for (int m = 0; m < WINDOW_DEPTH; m++) begin
			match[m] = (WLEN_W'(m) >= {1'b0, idx_q}) && (WLEN_W'(m) < len_q)
				&& (win_q[m].label == cur.label);
		end
	end
	assign scan_cnt = CNT_W'($countones(match));

	// Shared adder/subtractor: score accumulation, then divide steps.
	assign rem_sh = {rem_q, acc_q[SUM_W-1]};
	always_comb begin
		alu_a   = acc_q;
		alu_b   = (cur.label == top_label_q) ? SUM_W'(cur.score) : '0;
		alu_sub = 1'b0;
		if (state_q == ST_DIV) begin
			alu_a   = SUM_W'(rem_sh);
			alu_b   = SUM_W'(top_cnt_q);
			alu_sub = 1'b1;
		end
	end
	assign alu_y = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                       : ({1'b0, alu_a} + {1'b0, alu_b});
	assign q_bit = !alu_y[SUM_W];

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ld_direct = 1'b0;
		ld_vote   = 1'b0;
		to_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					if (len_c == '0) begin
						ld_direct = 1'b1;
						state_d   = ST_DONE;
					end else begin
						ld_vote = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (idx_last) state_d = ST_SUM;
			end
			ST_SUM: begin
				if (idx_last) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					to_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q         <= '0;
			best_score_q <= '0;
			best_label_q <= '0;
			cls_cnt_q    <= '0;
			m_valid_q    <= 1'b0;
			for (int m = 0; m < WINDOW_DEPTH; m++) begin
				win_q[m] <= '0;
			end
		end else begin
			if (cfg_we) wl_q <= cfg_wdata;
			if (s_fire) begin
				if (s_tlast) begin
					best_score_q <= '0;
					best_label_q <= '0;
					cls_cnt_q    <= '0;
				end else begin
					best_score_q <= nb.score;
					best_label_q <= nb.label;
					if (cls_cnt_q != CLASS_W'(MAX_CLASSES - 1)) cls_cnt_q <= cls_cnt_q + 1'b1;
				end
			end
			// Shift only the active part of the window.
			if (ld_vote) begin
				for (int m = 0; m < WINDOW_DEPTH; m++) begin
					if (WLEN_W'(m) < len_c) begin
						win_q[m] <= (m == 0) ? nb : win_q[(m == 0) ? 0 : m - 1];
					end
				end
			end
			if (to_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the sequencer and the output stage.
	always_ff @(posedge clk) begin
		if (ld_direct) begin
			res_label_q <= nb.label;
			res_score_q <= nb.score;
		end
		if (ld_vote) begin
			len_q       <= len_c;
			idx_q       <= WIDX_W'(len_c - 1'b1);
			top_cnt_q   <= '0;
			top_label_q <= '0;
			acc_q       <= '0;
		end
		unique case (state_q)
			ST_SCAN: begin
				if (scan_cnt > top_cnt_q) begin
					top_cnt_q   <= scan_cnt;
					top_label_q <= cur.label;
				end
				idx_q <= idx_last ? WIDX_W'(len_q - 1'b1) : idx_q - 1'b1;
			end
			ST_SUM: begin
				acc_q <= alu_y[SUM_W-1:0];
				idx_q <= idx_q - 1'b1;
				step_q <= '0;
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q  <= q_bit ? alu_y[CNT_W-1:0] : rem_sh[CNT_W-1:0];
				acc_q  <= {acc_q[SUM_W-2:0], q_bit};
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					res_label_q <= top_label_q;
					res_score_q <= {acc_q[SCORE_W-2:0], q_bit};
				end
			end
			ST_IDLE, ST_DONE: begin
			end
			default: begin
			end
		endcase
		if (to_out) begin
			m_label_q <= res_label_q[LABEL_W-1:0];
			m_score_q <= res_score_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W - LABEL_W - SCORE_W){1'b0}}, m_score_q, m_label_q};

	// The scan only visits entries inside the active window.
	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (len_q != '0) && ({1'b0, idx_q} < len_q))
		else $error("scan index outside window");

	// The divisor is a real count once scanning is over.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> (top_cnt_q != '0) && (top_cnt_q <= len_q))
		else $error("vote count out of range at divide");

	// The last divide step hands over to the result stage.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (step_q == STEP_W'(DIV_STEPS - 1)) |=> state_q == ST_DONE)
		else $error("divide did not finish");

	// A finished vote reaches the output as soon as the register is free.
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_free |=> m_tvalid && (state_q == ST_IDLE))
		else $error("result not moved to output");

endmodule
